// ===== sv/gbb_pkg.sv =====
// Types and constants shared by the glyph bounding box modules.
package gbb_pkg;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic CFG_CELL_WIDTH  = 1'b0;
    localparam logic CFG_CELL_HEIGHT = 1'b1;

    localparam int CFG_DW   = 9;
    localparam int IN_DW    = 40;
    localparam int OUT_DW   = 80;
    localparam int BOX_W    = 9;
    localparam int FONT_W   = 8;

    typedef struct packed {
        logic       op;
        logic       hit;
        logic [7:0] code;
    } gbb_pix_t;

    typedef struct packed {
        logic [7:0]              glyph_id;
        logic                    found;
        logic signed [BOX_W-1:0] box_top;
        logic signed [BOX_W-1:0] box_left;
        logic signed [BOX_W-1:0] box_right;
        logic signed [BOX_W-1:0] box_bottom;
        logic [FONT_W-1:0]       font_max_width;
        logic [FONT_W-1:0]       font_max_height;
        logic [FONT_W-1:0]       font_leftmost;
        logic [FONT_W-1:0]       font_topmost;
    } gbb_result_t;

endpackage

// ===== sv/gbb_in_stage.sv =====
// Input register: captures one word and reduces the pixel to a set bit.
module gbb_in_stage
    import gbb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_DW-1:0] s_tdata,
    input  logic             s_tuser,
    input  logic             dn_ready,
    output logic             pix_valid,
    output gbb_pix_t         pix
);

    logic     valid_reg;
    logic     valid_next;
    gbb_pix_t pix_reg;
    gbb_pix_t pix_next;
    logic     accept;

    assign s_tready = !valid_reg || dn_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        pix_next.op   = s_tuser;
        pix_next.hit  = ((s_tdata[7:0] | s_tdata[15:8] | s_tdata[23:16]) != s_tdata[31:24]);
        pix_next.code = s_tdata[39:32];
        if (accept)
            valid_next = 1'b1;
        else if (dn_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pix_reg <= pix_next;
    end

    assign pix_valid = valid_reg;
    assign pix       = pix_reg;

endmodule

// ===== sv/gbb_tracker.sv =====
// Cell position, glyph extents, font-wide extents and the result register.
module gbb_tracker
    import gbb_pkg::*;
#(
    parameter int CW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          restart,
    input  logic [CW-1:0] col_last,
    input  logic [CW-1:0] row_last,
    input  logic          pix_valid,
    input  gbb_pix_t      pix,
    output logic          pix_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output gbb_result_t   result
);

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [CW-1:0] min_col_reg, min_col_next;
    logic [CW-1:0] max_col_reg, max_col_next;
    logic [CW-1:0] min_row_reg, min_row_next;
    logic [CW-1:0] max_row_reg, max_row_next;
    logic          any_reg, any_next;
    logic [7:0]    widest_reg, widest_next;
    logic [7:0]    tallest_reg, tallest_next;
    logic [7:0]    left_reg, left_next;
    logic [7:0]    top_reg, top_next;
    logic          out_valid_reg, out_valid_next;
    gbb_result_t   result_reg, result_next;

    logic          is_pixel;
    logic          last_col;
    logic          last_row;
    logic          emit;
    logic          advance;
    logic [CW-1:0] gmin_col, gmax_col, gmin_row, gmax_row;
    logic          gany;
    logic [CW-1:0] span;

    assign is_pixel  = (pix.op == OP_PIXEL);
    assign last_col  = (col_reg == col_last);
    assign last_row  = (row_reg == row_last);
    assign emit      = is_pixel && last_col && last_row;
    assign pix_ready = !emit || !out_valid_reg || out_ready;
    assign advance   = pix_valid && pix_ready;

    always_comb
    begin
        gmin_col = (pix.hit && col_reg < min_col_reg) ? col_reg : min_col_reg;
        gmax_col = (pix.hit && col_reg > max_col_reg) ? col_reg : max_col_reg;
        gmin_row = (pix.hit && row_reg < min_row_reg) ? row_reg : min_row_reg;
        gmax_row = (pix.hit && row_reg > max_row_reg) ? row_reg : max_row_reg;
        gany     = any_reg || pix.hit;
        span     = gmax_col - gmin_col;

        col_next     = col_reg;
        row_next     = row_reg;
        min_col_next = min_col_reg;
        max_col_next = max_col_reg;
        min_row_next = min_row_reg;
        max_row_next = max_row_reg;
        any_next     = any_reg;
        widest_next  = widest_reg;
        tallest_next = tallest_reg;
        left_next    = left_reg;
        top_next     = top_reg;

        if (advance && !is_pixel)
        begin
            widest_next  = '0;
            tallest_next = '0;
            left_next    = '1;
            top_next     = '1;
        end
        else if (advance)
        begin
            min_col_next = gmin_col;
            max_col_next = gmax_col;
            min_row_next = gmin_row;
            max_row_next = gmax_row;
            any_next     = gany;
            col_next     = last_col ? '0 : col_reg + 1'b1;
            if (last_col)
                row_next = last_row ? '0 : row_reg + 1'b1;
            if (emit && gany)
            begin
                if (32'(gmax_row) > 32'(tallest_reg))
                    tallest_next = (32'(gmax_row) > 32'd255) ? 8'hFF : 8'(gmax_row);
                if (32'(span) > 32'(widest_reg))
                    widest_next = (32'(span) > 32'd255) ? 8'hFF : 8'(span);
                if (32'(gmin_col) < 32'(left_reg))
                    left_next = 8'(gmin_col);
                if (32'(gmin_row) < 32'(top_reg))
                    top_next = 8'(gmin_row);
            end
            if (emit)
            begin
                min_col_next = '1;
                max_col_next = '0;
                min_row_next = '1;
                max_row_next = '0;
                any_next     = 1'b0;
            end
        end

        if (restart)
        begin
            col_next     = '0;
            row_next     = '0;
            min_col_next = '1;
            max_col_next = '0;
            min_row_next = '1;
            max_row_next = '0;
            any_next     = 1'b0;
        end

        result_next.glyph_id        = pix.code;
        result_next.found           = gany;
        result_next.box_top         = gany ? BOX_W'(gmin_row) : '1;
        result_next.box_left        = gany ? BOX_W'(gmin_col) : '1;
        result_next.box_right       = gany ? BOX_W'(gmax_col) : '1;
        result_next.box_bottom      = gany ? BOX_W'(gmax_row) : '1;
        result_next.font_max_width  = widest_next;
        result_next.font_max_height = tallest_next;
        result_next.font_leftmost   = left_next;
        result_next.font_topmost    = top_next;

        if (advance && emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            min_col_reg   <= '1;
            max_col_reg   <= '0;
            min_row_reg   <= '1;
            max_row_reg   <= '0;
            any_reg       <= 1'b0;
            widest_reg    <= '0;
            tallest_reg   <= '0;
            left_reg      <= '1;
            top_reg       <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            min_col_reg   <= min_col_next;
            max_col_reg   <= max_col_next;
            min_row_reg   <= min_row_next;
            max_row_reg   <= max_row_next;
            any_reg       <= any_next;
            widest_reg    <= widest_next;
            tallest_reg   <= tallest_next;
            left_reg      <= left_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== sv/glyph_bounding_box.sv =====
// Glyph bounding box detector: top level, cell size registers and word packing.
//
//  channel   direction  word
//  s_*       in         pixel word, or font extent clear (tuser = 1)
//  m_*       out        glyph box and font extents, one per cell
//  cfg_*     in         cell_width (index 0), cell_height (index 1)
//
// One pixel word per cycle while tready is high; a cell's last pixel passes the input and result registers.
// Input register and result register decouple the sides; tready drops
// only while a finished result waits and the next word completes a cell.
// Reset: async, active low; cell size 16x16, font extents cleared.
// A cfg write restarts the current cell.
module glyph_bounding_box
    import gbb_pkg::*;
#(
    parameter int MAX_CELL_DIM = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_DW-1:0]  s_tdata,   // red, green, blue, background, glyph_code
    input  logic              s_tuser,   // op
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_DW-1:0] m_tdata,   // glyph_id, box_top, box_left, box_right,
                                         // box_bottom, font_max_width, font_max_height,
                                         // font_leftmost, font_topmost, zero pad
    output logic              m_tuser,   // found
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    localparam int CW = $clog2(MAX_CELL_DIM);

    logic [CFG_DW-1:0] cell_width_reg;
    logic [CFG_DW-1:0] cell_height_reg;
    logic [CW-1:0]     col_last;
    logic [CW-1:0]     row_last;
    logic              pix_valid;
    logic              pix_ready;
    gbb_pix_t          pix;
    gbb_result_t       result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg  <= CFG_DW'(16);
            cell_height_reg <= CFG_DW'(16);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_CELL_WIDTH:  cell_width_reg  <= cfg_wdata;
                CFG_CELL_HEIGHT: cell_height_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (32'(cell_width_reg) > MAX_CELL_DIM)
            col_last = CW'(MAX_CELL_DIM - 1);
        else if (cell_width_reg == '0)
            col_last = '0;
        else
            col_last = CW'(cell_width_reg - 1'b1);
        if (32'(cell_height_reg) > MAX_CELL_DIM)
            row_last = CW'(MAX_CELL_DIM - 1);
        else if (cell_height_reg == '0)
            row_last = '0;
        else
            row_last = CW'(cell_height_reg - 1'b1);
    end

    gbb_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .dn_ready  (pix_ready),
        .pix_valid (pix_valid),
        .pix       (pix)
    );

    gbb_tracker #(
        .CW (CW)
    ) u_trk (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (cfg_we),
        .col_last  (col_last),
        .row_last  (row_last),
        .pix_valid (pix_valid),
        .pix       (pix),
        .pix_ready (pix_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (result)
    );

    assign m_tuser = result.found;
    assign m_tdata = {4'd0,
                      result.font_topmost,
                      result.font_leftmost,
                      result.font_max_height,
                      result.font_max_width,
                      result.box_bottom,
                      result.box_right,
                      result.box_left,
                      result.box_top,
                      result.glyph_id};

`ifndef ASSERT_OFF
    a_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[16:8] == 9'h1FF && m_tdata[43:35] == 9'h1FF)
        else $error("empty glyph without -1 box");

    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[25:17] <= m_tdata[34:26]
                                && m_tdata[16:8] <= m_tdata[43:35])
        else $error("glyph box inverted");

    a_font_left: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> {1'b0, m_tdata[67:60]} <= m_tdata[25:17]
                                && {1'b0, m_tdata[75:68]} <= m_tdata[16:8])
        else $error("font extent not covering glyph");
`endif

endmodule
